[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

[rtl/lgge_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_pkg
// shared types and constants of the life grid generation engine
// ----------------------------------------------------------------------------
package lgge_pkg;

   localparam int MAX_GRID_WIDTH_DEF  = 256;
   localparam int MAX_GRID_HEIGHT_DEF = 64;

   localparam logic [8:0] GRID_WIDTH_RESET  = 9'd230;
   localparam logic [6:0] GRID_HEIGHT_RESET = 7'd50;

   // operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   // csr register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] cell_x;
      logic [5:0] cell_y;
      logic       set_alive;
   } req_word_type;

   typedef struct packed {
      logic alive_out;
      logic coordinate_error;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL_RD,
      ST_CELL_DONE,
      ST_ADV_LOAD,
      ST_ADV_ROW
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic cell_rd;
      logic cell_wr;
      logic clr_wr;
      logic adv_start;
      logic adv_load;
      logic adv_row;
      logic rsp_load;
      logic rsp_err;
      logic rsp_read;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       coord_bad;
      logic [1:0] held_op;
      logic       clr_last;
      logic       adv_last;
   } dp_status_type;

endpackage

[rtl/lgge_row_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_row_rule
// b3/s23 update of one full grid row from a three row window
// ----------------------------------------------------------------------------
module lgge_row_rule #(
   parameter int WIDTH = lgge_pkg::MAX_GRID_WIDTH_DEF
) (
   input  logic [WIDTH-1:0] prev_row,
   input  logic [WIDTH-1:0] cur_row,
   input  logic [WIDTH-1:0] next_row,
   input  logic [WIDTH-1:0] col_mask,
   output logic [WIDTH-1:0] new_row
);

   logic [WIDTH+1:0] p_pad;
   logic [WIDTH+1:0] c_pad;
   logic [WIDTH+1:0] n_pad;
   logic [3:0]       count;

   always_comb begin
      // columns outside the used width read as dead
      p_pad = {1'b0, prev_row & col_mask, 1'b0};
      c_pad = {1'b0, cur_row  & col_mask, 1'b0};
      n_pad = {1'b0, next_row & col_mask, 1'b0};
      count = '0;
      new_row = cur_row;
      for (int c = 0; c < WIDTH; c++) begin
         count = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
               + 4'(c_pad[c])                  + 4'(c_pad[c+2])
               + 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2]);
         if (col_mask[c]) begin
            new_row[c] = (count == 4'd3) || (cur_row[c] && (count == 4'd2));
         end
      end
   end

endmodule

[rtl/lgge_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_ctrl
// sequencer for clearing, cell access and generation sweeps
// ----------------------------------------------------------------------------
module lgge_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_operation,
   input  lgge_pkg::dp_status_type status,
   output lgge_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   lgge_pkg::state_type state_ff;
   lgge_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgge_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != lgge_pkg::ST_IDLE);
      case (state_ff)
         lgge_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = lgge_pkg::ST_IDLE;
            end
         end
         lgge_pkg::ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               case (req_operation)
                  lgge_pkg::OP_WRITE, lgge_pkg::OP_READ: begin
                     if (status.coord_bad) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_err  = 1'b1;
                     end else begin
                        state_in = lgge_pkg::ST_CELL_RD;
                     end
                  end
                  lgge_pkg::OP_ADVANCE: begin
                     cmd.adv_start = 1'b1;
                     state_in      = lgge_pkg::ST_ADV_LOAD;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         lgge_pkg::ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = lgge_pkg::ST_CELL_DONE;
         end
         lgge_pkg::ST_CELL_DONE: begin
            cmd.rsp_load = 1'b1;
            if (status.held_op == lgge_pkg::OP_READ) begin
               cmd.rsp_read = 1'b1;
            end else begin
               cmd.cell_wr = 1'b1;
            end
            state_in = lgge_pkg::ST_IDLE;
         end
         lgge_pkg::ST_ADV_LOAD: begin
            cmd.adv_load = 1'b1;
            state_in     = lgge_pkg::ST_ADV_ROW;
         end
         lgge_pkg::ST_ADV_ROW: begin
            cmd.adv_row = 1'b1;
            if (status.adv_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = lgge_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lgge_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/lgge_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_datapath
// grid row memory, row window, size registers and result register
// ----------------------------------------------------------------------------
module lgge_datapath #(
   parameter int MAX_GRID_WIDTH  = lgge_pkg::MAX_GRID_WIDTH_DEF,
   parameter int MAX_GRID_HEIGHT = lgge_pkg::MAX_GRID_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lgge_pkg::req_word_type              req_word,
   input  logic                                csr_valid,
   input  logic [lgge_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lgge_pkg::CSR_DATA_W-1:0]     csr_data,
   input  lgge_pkg::ctrl_cmd_type              cmd,
   output lgge_pkg::dp_status_type             status,
   output logic                                rsp_strobe,
   output lgge_pkg::rsp_word_type              rsp_word
);

   localparam int COL_AW  = $clog2(MAX_GRID_WIDTH);
   localparam int ROW_AW  = $clog2(MAX_GRID_HEIGHT);
   localparam int UW_BITS = $clog2(MAX_GRID_WIDTH + 1);
   localparam int UH_BITS = $clog2(MAX_GRID_HEIGHT + 1);
   localparam int WCW     = (UW_BITS > 8 ? UW_BITS : 8) + 1;
   localparam int HCW     = (UH_BITS > 7 ? UH_BITS : 7) + 1;

   logic [MAX_GRID_WIDTH-1:0] grid_mem [MAX_GRID_HEIGHT];

   logic [8:0]                width_ff;
   logic [6:0]                height_ff;
   lgge_pkg::req_word_type    held_ff;
   logic [HCW-1:0]            row_ff;
   logic [HCW-1:0]            row_in;
   logic [MAX_GRID_WIDTH-1:0] col_mask_ff;
   logic [MAX_GRID_WIDTH-1:0] col_mask_in;
   logic [MAX_GRID_WIDTH-1:0] rd_data_ff;
   logic [MAX_GRID_WIDTH-1:0] prev_ff;
   logic [MAX_GRID_WIDTH-1:0] cur_ff;
   logic                      rsp_strobe_ff;
   lgge_pkg::rsp_word_type    rsp_word_ff;
   lgge_pkg::rsp_word_type    rsp_word_in;

   logic [WCW-1:0]            w_ext;
   logic [WCW-1:0]            used_w;
   logic [HCW-1:0]            h_ext;
   logic [HCW-1:0]            used_h;
   logic [HCW-1:0]            row_p1;
   logic [HCW-1:0]            row_p2;
   logic [COL_AW-1:0]         x_idx;
   logic [ROW_AW-1:0]         y_idx;
   logic                      rd_en;
   logic [ROW_AW-1:0]         rd_addr;
   logic                      wr_en;
   logic [ROW_AW-1:0]         wr_addr;
   logic [MAX_GRID_WIDTH-1:0] wr_data;
   logic [MAX_GRID_WIDTH-1:0] cell_row;
   logic [MAX_GRID_WIDTH-1:0] next_row;
   logic [MAX_GRID_WIDTH-1:0] new_row;

   // size clamps to 1..max
   always_comb begin
      w_ext  = WCW'(width_ff);
      h_ext  = HCW'(height_ff);
      used_w = (w_ext == '0) ? WCW'(1)
             : (w_ext > WCW'(MAX_GRID_WIDTH)) ? WCW'(MAX_GRID_WIDTH) : w_ext;
      used_h = (h_ext == '0) ? HCW'(1)
             : (h_ext > HCW'(MAX_GRID_HEIGHT)) ? HCW'(MAX_GRID_HEIGHT) : h_ext;
      for (int c = 0; c < MAX_GRID_WIDTH; c++) begin
         col_mask_in[c] = WCW'(c) < used_w;
      end
   end

   always_comb begin
      row_p1 = row_ff + HCW'(1);
      row_p2 = row_ff + HCW'(2);
      x_idx  = COL_AW'(held_ff.cell_x);
      y_idx  = ROW_AW'(held_ff.cell_y);

      status.coord_bad = (WCW'(req_word.cell_x) >= used_w)
                      || (HCW'(req_word.cell_y) >= used_h);
      status.held_op   = held_ff.operation;
      status.clr_last  = (row_ff == HCW'(MAX_GRID_HEIGHT - 1));
      status.adv_last  = (row_p1 == used_h);

      cell_row = rd_data_ff;
      cell_row[x_idx] = held_ff.set_alive;
      next_row = status.adv_last ? '0 : rd_data_ff;

      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.cell_rd) begin
         rd_en   = 1'b1;
         rd_addr = y_idx;
      end else if (cmd.adv_start) begin
         rd_en   = 1'b1;
      end else if (cmd.adv_load) begin
         rd_en   = (HCW'(1) < used_h);
         rd_addr = ROW_AW'(1);
      end else if (cmd.adv_row) begin
         rd_en   = (row_p2 < used_h);
         rd_addr = row_p2[ROW_AW-1:0];
      end

      wr_en   = cmd.cell_wr | cmd.clr_wr | cmd.adv_row;
      wr_addr = cmd.cell_wr ? y_idx : row_ff[ROW_AW-1:0];
      wr_data = cmd.cell_wr ? cell_row : (cmd.adv_row ? new_row : '0);

      row_in = row_ff;
      if (cmd.adv_start) begin
         row_in = '0;
      end else if (cmd.clr_wr || cmd.adv_row) begin
         row_in = row_p1;
      end

      rsp_word_in.alive_out        = cmd.rsp_read & rd_data_ff[x_idx];
      rsp_word_in.coordinate_error = cmd.rsp_err;
   end

   lgge_row_rule #(
      .WIDTH (MAX_GRID_WIDTH)
   ) u_row_rule (
      .prev_row (prev_ff),
      .cur_row  (cur_ff),
      .next_row (next_row),
      .col_mask (col_mask_ff),
      .new_row  (new_row)
   );

   // grid rows
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lgge_pkg::GRID_WIDTH_RESET;
         height_ff     <= lgge_pkg::GRID_HEIGHT_RESET;
         row_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               lgge_pkg::CSR_GRID_WIDTH:  width_ff  <= csr_data[8:0];
               lgge_pkg::CSR_GRID_HEIGHT: height_ff <= csr_data[6:0];
               default: ;
            endcase
         end
         row_ff        <= row_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_mask_ff <= col_mask_in;
      if (cmd.latch_req) begin
         held_ff <= req_word;
      end
      if (cmd.adv_start) begin
         prev_ff <= '0;
      end else if (cmd.adv_row) begin
         prev_ff <= cur_ff;
      end
      if (cmd.adv_load || cmd.adv_row) begin
         cur_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

[rtl/life_grid_generation_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine_core
// bounded b3/s23 life grid with cell write, cell read and generation advance
// ----------------------------------------------------------------------------
//
//   channel   handshake                  word
//   --------  -------------------------  -----------------------------------
//   request   start / busy               operation, cell_x, cell_y, set_alive
//   response  rsp_strobe (one cycle)     alive_out, coordinate_error
//   csr       csr_valid / csr_ready      csr_index, csr_data
//
// a bad coordinate or an unused operation answers in the cycle after accept
// a cell read or write answers after ST_CELL_RD (row read) and ST_CELL_DONE
// (for a write, read-modify-write of the row)
// an advance loads row 0 in ST_ADV_LOAD; then in ST_ADV_ROW one grid row
// is read and one written per cycle, the update running over all columns
// after reset a clearing pass over all MAX_GRID_HEIGHT rows holds busy high
// the receiver cannot stall, so a word is never held back
//
module life_grid_generation_engine_core #(
   parameter int MAX_GRID_WIDTH  = lgge_pkg::MAX_GRID_WIDTH_DEF,
   parameter int MAX_GRID_HEIGHT = lgge_pkg::MAX_GRID_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  lgge_pkg::req_word_type           req_word,
   // response channel
   output logic                             rsp_strobe,
   output lgge_pkg::rsp_word_type           rsp_word,
   // csr write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lgge_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lgge_pkg::CSR_DATA_W-1:0]  csr_data
);

`include "assert_macros.svh"

   lgge_pkg::ctrl_cmd_type  cmd;
   lgge_pkg::dp_status_type status;
   logic                    accept;
   logic                    cell_op;
   logic                    bad_accept;
   logic                    adv_accept;

   // size registers are always writable
   assign csr_ready = 1'b1;

   assign accept     = start & ~busy;
   assign cell_op    = req_word.operation inside {lgge_pkg::OP_WRITE, lgge_pkg::OP_READ};
   assign bad_accept = accept & cell_op & status.coord_bad;
   assign adv_accept = accept & (req_word.operation == lgge_pkg::OP_ADVANCE);

   // sequencer
   lgge_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_word.operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   // grid storage and row engine
   lgge_datapath #(
      .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
      .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // every response is given with the sequencer back in idle
   `ASSERT_IMPLIES(a_rsp_when_idle, clock, reset, rsp_strobe, !busy)

   // an out of range cell access answers straight from idle, through the response register, with the error flag
   `ASSERT_NEXT(a_err_rsp, clock, reset, bad_accept, rsp_strobe && rsp_word.coordinate_error)

   // an advance keeps the engine busy past its accept cycle
   `ASSERT_NEXT(a_adv_busy, clock, reset, adv_accept, busy && !rsp_strobe)

endmodule
